// File: hw/rtl/trial_division_prime_test_top_macros.svh
// Assertion helpers shared by the prime test RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

  // default operand width
  localparam int TDPT_VALUE_WIDTH = 32;

  // 6k +/- 1 sieve constants
  localparam int TDPT_FIRST_DIVISOR  = 5;
  localparam int TDPT_DIVISOR_STEP   = 6;
  localparam int TDPT_PAIR_OFFSET    = 2;
  localparam int TDPT_SMALL_PRIME_MAX = 3;

endpackage

`default_nettype wire

// File: hw/rtl/tdpt_div.sv
`default_nettype none

`include "trial_division_prime_test_top_macros.svh"

// Restoring divider, one quotient bit per cycle.
module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = TDPT_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [VALUE_WIDTH-1:0]      remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] den_r, den_nxt;
  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;

  assign partial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff    = partial - {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(VALUE_WIDTH);
      rem_nxt = '0;
      quo_nxt = dividend;
      den_nxt = divisor;
    end else if (run_r) begin
      // dividend bits shift out at the top, quotient bits in at the bottom
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = partial[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `TDPT_ASSERT_SAME(a_done_not_running, done_r, !run_r, "divider done while still running")
  `TDPT_ASSERT_SAME(a_no_restart, start, !run_r, "divider restarted mid-division")
  `TDPT_ASSERT_SAME(a_rem_below_den, run_r && (den_r != '0), rem_r < den_r,
                    "partial remainder not below divisor")

endmodule

`default_nettype wire

// File: hw/rtl/trial_division_prime_test_top.sv
`default_nettype none

// Channel   Ports                          Handshake
// input     in_n_value                     taken when start && !busy
// result    out_is_prime                   one cycle, marked by out_valid
//
// Values 0..3 and even values are answered the cycle after start.
// Others run trial divisions on one shared bit-serial divider:
// first by 3, then by i and i+2 for i = 5, 11, 17, ... while
// i <= n / i. Worst case at 32 bits (a prime near 2^32) is about
// 21850 divisions. Synchronous active-low reset returns the sequencer
// to idle. The receiver cannot stall; a new item may start while
// out_valid is high.

`include "trial_division_prime_test_top_macros.svh"

module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = TDPT_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] in_n_value,
  output logic                        out_valid,
  output logic                        out_is_prime
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_MOD3  = 2'd1;  // dividing by 3
  localparam logic [1:0] ST_DIV_A = 2'd2;  // dividing by i, quotient gives the bound
  localparam logic [1:0] ST_DIV_B = 2'd3;  // dividing by i + 2

  localparam logic [VALUE_WIDTH-1:0] ONE   = VALUE_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] THREE = VALUE_WIDTH'(TDPT_SMALL_PRIME_MAX);
  localparam logic [VALUE_WIDTH-1:0] FIRST = VALUE_WIDTH'(TDPT_FIRST_DIVISOR);
  localparam logic [VALUE_WIDTH-1:0] STEP  = VALUE_WIDTH'(TDPT_DIVISOR_STEP);
  localparam logic [VALUE_WIDTH-1:0] PAIR  = VALUE_WIDTH'(TDPT_PAIR_OFFSET);

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;        // item under test
  logic [VALUE_WIDTH-1:0] i_r, i_nxt;        // current 6k-1 divisor
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  tdpt_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    div_start     = 1'b0;
    div_dividend  = n_r;
    div_divisor   = i_r;
    unique case (state_r)
      ST_IDLE: begin
        div_dividend = in_n_value;
        div_divisor  = THREE;
        if (start) begin
          n_nxt = in_n_value;
          if (in_n_value <= ONE) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else if (in_n_value <= THREE) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
          end else if (!in_n_value[0]) begin
            // even and above two
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_MOD3;
          end
        end
      end
      ST_MOD3: begin
        div_divisor = FIRST;
        if (div_done) begin
          if (div_rem == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            i_nxt     = FIRST;
            div_start = 1'b1;
            state_nxt = ST_DIV_A;
          end
        end
      end
      ST_DIV_A: begin
        div_divisor = i_r + PAIR;
        if (div_done) begin
          if (i_r > div_quo) begin
            // i*i > n: no divisor left to try
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (div_rem == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV_B;
          end
        end
      end
      ST_DIV_B: begin
        div_divisor = i_r + STEP;
        if (div_done) begin
          if (div_rem == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            i_nxt     = i_r + STEP;
            div_start = 1'b1;
            state_nxt = ST_DIV_A;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  `TDPT_ASSERT_SAME(a_result_when_idle, out_valid, !busy, "result shown while still busy")
  `TDPT_ASSERT_NEXT(a_small_composite, start && !busy && (in_n_value <= ONE),
                    out_valid && !out_is_prime, "0 or 1 not reported composite")
  `TDPT_ASSERT_NEXT(a_small_prime,
                    start && !busy && ((in_n_value == PAIR) || (in_n_value == THREE)),
                    out_valid && out_is_prime, "2 or 3 not reported prime")

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tdpt_pkg::*;

  localparam int W = TDPT_VALUE_WIDTH;

  // One queued test value and the idle cycles the driver leaves before it.
  typedef struct {
    logic [W-1:0] value;
    int unsigned  gap;
  } test_item_t;

  // What the monitor waits for: the verdict, plus the value for the log.
  typedef struct {
    logic [W-1:0] value;
    bit           verdict;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic [W-1:0] in_n_value = '0;
  logic         busy;
  logic         out_valid;
  logic         out_is_prime;

  test_item_t   values_queued[$];
  verdict_t     verdicts_due[$];
  bit           item_taken = 1'b0;
  int unsigned  faults = 0;

  // Hand-picked values: the tiny cases, squares and twin products of small
  // primes (the i*i == n boundary), a few known primes and large values
  // with the top bits set.
  logic [W-1:0] hand_picked[$] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 35, 49, 121, 143, 289, 323,
    65521, 65537, 1000003, 16777213, 32'd4093012279,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFE
  };

  trial_division_prime_test_top #(
    .VALUE_WIDTH(W)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_n_value  (in_n_value),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trial division by 2, 3, then i and i+2 for i = 5, 11, 17, ...
  // Done in 64 bits so i*i never wraps; bound is i <= n / i.
  function automatic bit is_prime_by_division(logic [W-1:0] n);
    longint unsigned v;
    longint unsigned i;
    v = 64'(n);
    if (v < 2) return 1'b0;
    if (v <= TDPT_SMALL_PRIME_MAX) return 1'b1;
    if (v % 2 == 0 || v % 3 == 0) return 1'b0;
    for (i = TDPT_FIRST_DIVISOR; i <= v / i; i += TDPT_DIVISOR_STEP)
      if (v % i == 0 || v % (i + TDPT_PAIR_OFFSET) == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly back-to-back or short gaps, the odd long one.
  function automatic int unsigned draw_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 200);
  endfunction

  // Driver: changes inputs on the falling edge. start stays up until the
  // monitor has seen the item taken; gap counts down only while idle.
  always @(negedge clk) begin
    logic         next_start;
    logic [W-1:0] next_value;
    next_start = start;
    next_value = in_n_value;
    if (rst_n && (!start || item_taken)) begin
      next_start = 1'b0;
      if (values_queued.size() != 0) begin
        if (values_queued[0].gap != 0) begin
          values_queued[0].gap--;
        end else begin
          next_value = values_queued[0].value;
          next_start = 1'b1;
          values_queued.pop_front();
        end
      end
    end
    start      <= next_start;
    in_n_value <= next_value;
  end

  // Monitor: samples on the rising edge. The result check comes before the
  // push, since a result never belongs to an item taken on the same edge.
  always @(posedge clk) begin
    verdict_t due;
    item_taken = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, is_prime=%b with no item outstanding",
                   $time, out_is_prime);
          faults++;
        end else begin
          due = verdicts_due.pop_front();
          if (out_is_prime !== due.verdict) begin
            $display("%0t: n=%0d is_prime expected %b, got %b",
                     $time, due.value, due.verdict, out_is_prime);
            faults++;
          end
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        verdicts_due.push_back('{value: in_n_value,
                                 verdict: is_prime_by_division(in_n_value)});
      end
    end
  end

  initial begin
    test_item_t      item;
    int unsigned     pick;
    longint unsigned a;
    longint unsigned b;
    logic [W-1:0]    v;

    foreach (hand_picked[k]) begin
      item.value = hand_picked[k];
      item.gap   = draw_gap(1'b0);
      values_queued.push_back(item);
    end

    // Random part. Run time per item grows with the smallest factor (or
    // sqrt(n) for a prime), so large values are kept cheap: even,
    // multiples of 3, or built with a small factor. Items 30..49 go
    // back to back.
    for (int k = 0; k < 75; k++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: begin
          v = $urandom & ~32'd1;
        end
        2: begin
          v = ($urandom % 32'd1431655765) * 3;
        end
        3, 4: begin
          v = $urandom_range(0, 4095);
        end
        5, 6: begin
          v = $urandom_range(0, (1 << 20) - 1);
        end
        7, 8: begin
          a = 64'($urandom_range(2, 1500));
          b = 64'($urandom_range(0, 32'(64'hFFFF_FFFF / a)));
          v = W'(a * b);
        end
        default: begin
          // around the square of an odd p: the divisor bound is exact here
          a = 64'($urandom_range(2, 500) * 2 + 1);
          b = a + 64'(2 * $urandom_range(0, 1));
          v = W'(a * b);
          if ($urandom_range(0, 3) == 0) v = v + 2;
        end
      endcase
      item.value = v;
      item.gap   = draw_gap(k >= 30 && k < 50);
      values_queued.push_back(item);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (values_queued.size() != 0 || start || verdicts_due.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (50) @(posedge clk);

    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
